// ----- rtl/core/nhb_pkg.sv -----
`default_nettype none

package nhb_pkg;

    localparam int HASH_W     = 24;
    localparam int BYTE_W     = 8;
    localparam int CHAR_W     = 7;
    localparam int DIGIT_W    = 6;
    localparam int RADIX      = 36;
    localparam int TAG_DIGITS = 4;

    localparam logic [HASH_W-1:0] HASH_MASK = 24'hFF_FFFF;

    // The tag is the low TAG_DIGITS base-36 digits of the hash. The hash is scaled by
    // a rounded-up reciprocal of RADIX**TAG_DIGITS. The fraction of that product is
    // then unpacked one digit per step by multiplying by 36. FRAC_W leaves enough guard
    // bits that no digit is ever off by one.
    localparam longint unsigned TAG_MOD = longint'(RADIX) ** TAG_DIGITS;
    localparam int FRAC_W  = HASH_W + $clog2(TAG_MOD);
    localparam longint unsigned RECIP = ((64'd1 << FRAC_W) + TAG_MOD - 64'd1) / TAG_MOD;
    localparam int RECIP_W = FRAC_W - $clog2(TAG_MOD) + 1;
    localparam int PROD_W  = HASH_W + RECIP_W;
    localparam int LEFT_W  = $clog2(TAG_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [DIGIT_W-1:0] DECIMAL_DIGITS = 6'd10;
    localparam logic [BYTE_W-1:0] NAME_END = 8'h00;

    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
        logic              upper;
    } tag_job_t;

    // One shift-add step. Bits that move above the hash width are cleared and
    // folded back into the low byte.
    function automatic logic [HASH_W-1:0] hash_fold(input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_W-1:0] b);
        logic [HASH_W+4:0] sum;
        begin
            sum = {1'b0, h, 4'b0000} + (HASH_W+5)'(b);
            return (sum[HASH_W-1:0] & HASH_MASK) ^ HASH_W'(sum[HASH_W+4:HASH_W]);
        end
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic upper);
        logic [CHAR_W-1:0] letter_base;
        begin
            letter_base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
            if (d < DECIMAL_DIGITS)
                return CHAR_ZERO + CHAR_W'(d);
            return letter_base + CHAR_W'(d - DECIMAL_DIGITS);
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nhb_hash.sv -----
`default_nettype none

module nhb_hash
    import nhb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              name_valid,
    output logic                   name_stall,
    input  wire logic [BYTE_W-1:0] name_byte,
    input  wire logic              upper_case,
    input  wire logic              job_ready,
    output tag_job_t               job
);

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic              is_end;
    logic              accept;

    assign is_end = (name_byte == NAME_END);

    // Only a terminator needs room in the tag stage; ordinary bytes always flow.
    assign name_stall = is_end && !job_ready;
    assign accept     = name_valid && !name_stall;

    always_comb
    begin
        hash_next = hash_reg;
        if (accept)
        begin
            if (is_end)
                hash_next = '0;
            else
                hash_next = hash_fold(hash_reg, name_byte);
        end
    end

    assign job.valid = accept && is_end;
    assign job.hash  = hash_reg;
    assign job.upper = upper_case;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_reg <= '0;
        else
            hash_reg <= hash_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/nhb_tag.sv -----
`default_nettype none

module nhb_tag
    import nhb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tag_job_t           job,
    output logic                    job_ready,
    output logic                    tag_valid,
    input  wire logic               tag_stall,
    output logic [CHAR_W-1:0]       tag_char,
    output logic [HASH_W-1:0]       hash_value,
    output logic                    last_of_tag
);

    // Scale stage: holds the fraction of hash * RECIP for one finished name.
    logic              a_valid_reg;
    logic [FRAC_W-1:0] a_frac_reg;
    logic [HASH_W-1:0] a_hash_reg;
    logic              a_upper_reg;

    // Serializer: remaining digits of the tag that is being sent.
    logic              ser_active_reg;
    logic [LEFT_W-1:0] left_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic [HASH_W-1:0] ser_hash_reg;
    logic              ser_upper_reg;

    logic              out_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [HASH_W-1:0] hash_out_reg;
    logic              last_reg;

    logic [PROD_W-1:0] prod;
    logic              out_free;
    logic              a_take;
    logic              issue;
    logic [FRAC_W-1:0] src_frac;
    logic [HASH_W-1:0] src_hash;
    logic              src_upper;
    logic [LEFT_W-1:0] src_left;
    logic [FRAC_W+5:0] times36;
    logic [DIGIT_W-1:0] digit;

    assign prod = PROD_W'(job.hash) * PROD_W'(RECIP);

    assign out_free  = !out_valid_reg || !tag_stall;
    assign issue     = out_free && (ser_active_reg || a_valid_reg);
    assign a_take    = a_valid_reg && !ser_active_reg && out_free;
    assign job_ready = !a_valid_reg || a_take;

    assign src_frac  = ser_active_reg ? frac_reg      : a_frac_reg;
    assign src_hash  = ser_active_reg ? ser_hash_reg  : a_hash_reg;
    assign src_upper = ser_active_reg ? ser_upper_reg : a_upper_reg;
    assign src_left  = ser_active_reg ? left_reg      : LEFT_W'(TAG_DIGITS - 1);

    // The integer part of fraction * 36 is the next digit, most significant first.
    assign times36 = {src_frac, 5'b00000} + {3'b000, src_frac, 2'b00};
    assign digit   = times36[FRAC_W+5:FRAC_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            ser_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (job.valid)
                a_valid_reg <= 1'b1;
            else if (a_take)
                a_valid_reg <= 1'b0;

            if (issue)
            begin
                ser_active_reg <= (src_left != '0);
                out_valid_reg  <= 1'b1;
            end
            else if (!tag_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job.valid)
        begin
            a_frac_reg  <= FRAC_W'(prod);
            a_hash_reg  <= job.hash;
            a_upper_reg <= job.upper;
        end
        if (issue)
        begin
            left_reg      <= src_left - LEFT_W'(1);
            frac_reg      <= times36[FRAC_W-1:0];
            ser_hash_reg  <= src_hash;
            ser_upper_reg <= src_upper;
            char_reg      <= digit_char(digit, src_upper);
            hash_out_reg  <= src_hash;
            last_reg      <= (src_left == '0);
        end
    end

    assign tag_valid   = out_valid_reg;
    assign tag_char    = char_reg;
    assign hash_value  = hash_out_reg;
    assign last_of_tag = last_reg;

    a_job_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        job.valid |-> job_ready)
        else $error("tag job pushed while the scale stage is full");

    a_ser_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        ser_active_reg |-> (left_reg < LEFT_W'(TAG_DIGITS - 1)))
        else $error("serializer digit count out of range");

    a_ser_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        ser_active_reg |-> out_valid_reg)
        else $error("serializer running while the output word is empty");

    a_char_in_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
        tag_valid |-> ((tag_char >= CHAR_ZERO && tag_char < CHAR_ZERO + 7'd10)
                    || (tag_char >= CHAR_UPPER_A && tag_char < CHAR_UPPER_A + 7'd26)
                    || (tag_char >= CHAR_LOWER_A && tag_char < CHAR_LOWER_A + 7'd26)))
        else $error("tag character outside the base-36 alphabet");

    a_last_ends_tag: assert property (@(posedge clk) disable iff (!rst_n)
        issue && (src_left == '0) |=> !ser_active_reg)
        else $error("serializer kept running after the last digit");

endmodule

`default_nettype wire

// ----- rtl/core/name_hash_base36_tag.sv -----
// Name hash with base-36 tag: each nonzero name byte updates a 24-bit hash in the cycle it is taken.
// Throughput: one name byte per cycle, but a terminator can stall; it yields four tag words.
// A second terminator waits only while the scale stage still holds an earlier tag.
// The terminator's hash * reciprocal product is registered in the scale stage, and then
// a times-36 digit serializer registers each tag word in the output word, as tag_stall allows.
// Reset (asynchronous, active low) clears the hash and empties every stage.
`default_nettype none

module name_hash_base36_tag
    import nhb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              name_valid,
    output logic                   name_stall,
    input  wire logic [BYTE_W-1:0] name_byte,
    input  wire logic              upper_case,
    output logic                   tag_valid,
    input  wire logic              tag_stall,
    output logic [CHAR_W-1:0]      tag_char,
    output logic [HASH_W-1:0]      hash_value,
    output logic                   last_of_tag
);

    tag_job_t job;
    logic     job_ready;

    nhb_hash u_hash (
        .clk        (clk),
        .rst_n      (rst_n),
        .name_valid (name_valid),
        .name_stall (name_stall),
        .name_byte  (name_byte),
        .upper_case (upper_case),
        .job_ready  (job_ready),
        .job        (job)
    );

    nhb_tag u_tag (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (job),
        .job_ready   (job_ready),
        .tag_valid   (tag_valid),
        .tag_stall   (tag_stall),
        .tag_char    (tag_char),
        .hash_value  (hash_value),
        .last_of_tag (last_of_tag)
    );

endmodule

`default_nettype wire

// ----- tb/tb_name_hash_base36_tag.sv -----
`timescale 1ns / 1ps

module tb_name_hash_base36_tag;
    import nhb_pkg::*;

    localparam int RANDOM_WORDS = 250;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [BYTE_W-1:0]       byte_v;
        logic                    upper;
        logic                    typed;
        logic [HASH_W-1:0]       exp_hash;
        logic [8*TAG_DIGITS-1:0] exp_tag;
    } stim_row_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [HASH_W-1:0] hash;
        logic              last;
    } tag_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic name_valid = 1'b0;
    logic name_stall;
    logic [BYTE_W-1:0] name_byte = '0;
    logic upper_case = 1'b0;
    logic tag_valid;
    logic tag_stall = 1'b0;
    logic [CHAR_W-1:0] tag_char;
    logic [HASH_W-1:0] hash_value;
    logic last_of_tag;

    logic [HASH_W-1:0] name_hash = '0;
    tag_word_t tag_words_due[$];
    stim_row_t directed_rows[$];
    int mismatches = 0;
    int unsigned rx_hold = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    name_hash_base36_tag dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .name_valid (name_valid),
        .name_stall (name_stall),
        .name_byte  (name_byte),
        .upper_case (upper_case),
        .tag_valid  (tag_valid),
        .tag_stall  (tag_stall),
        .tag_char   (tag_char),
        .hash_value (hash_value),
        .last_of_tag(last_of_tag)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Shift the hash left by four bits and add the byte, then fold whatever rose above bit 23 back
    // into the low byte.
    function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_W-1:0] b);
        logic [31:0] wide;
        begin
            wide = {4'h0, h, 4'h0} + {24'h0, b};
            return wide[HASH_W-1:0] ^ {16'h0, wide[31:HASH_W]};
        end
    endfunction

    function automatic logic [CHAR_W-1:0] base36_char(input int unsigned d, input logic upper);
        begin
            if (d < DECIMAL_DIGITS)
                return CHAR_ZERO + CHAR_W'(d);
            return (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(d - DECIMAL_DIGITS);
        end
    endfunction

    // Advance the running hash for one accepted word and queue the tag that a
    // terminator produces.
    task automatic apply_word(input stim_row_t r);
        int unsigned rest;
        int unsigned digs[TAG_DIGITS];
        tag_word_t w;
        begin
            if (r.byte_v != NAME_END) begin
                name_hash = hash_step(name_hash, r.byte_v);
            end
            else begin
                rest = {8'h00, name_hash};
                for (int i = TAG_DIGITS - 1; i >= 0; i--) begin
                    digs[i] = rest % RADIX;
                    rest = rest / RADIX;
                end
                for (int i = 0; i < TAG_DIGITS; i++) begin
                    if (r.typed) begin
                        w.ch   = r.exp_tag[8*(TAG_DIGITS-i)-2 -: CHAR_W];
                        w.hash = r.exp_hash;
                    end
                    else begin
                        w.ch   = base36_char(digs[i], r.upper);
                        w.hash = name_hash;
                    end
                    w.last = (i == TAG_DIGITS - 1);
                    tag_words_due.push_back(w);
                end
                name_hash = '0;
            end
        end
    endtask

    task automatic send_word(input stim_row_t r);
        int unsigned gap;
        begin
            gap = tx_steady ? 0 : $urandom_range(0, 9);
            if (gap != 0) begin
                name_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            name_valid <= 1'b1;
            name_byte  <= r.byte_v;
            upper_case <= r.upper;
            @(posedge clk);
            while (name_stall)
                @(posedge clk);
            apply_word(r);
        end
    endtask

    task automatic add_row(input logic [BYTE_W-1:0] b, input logic u, input logic typed,
                           input logic [HASH_W-1:0] h, input logic [8*TAG_DIGITS-1:0] tag);
        stim_row_t r;
        begin
            r.byte_v   = b;
            r.upper    = u;
            r.typed    = typed;
            r.exp_hash = h;
            r.exp_tag  = tag;
            directed_rows.push_back(r);
        end
    endtask

    always @(posedge clk)
    begin : tag_check
        tag_word_t want;
        int unsigned next_hold;
        next_hold = rx_hold;
        if (tag_valid && !tag_stall) begin
            if (tag_words_due.size() == 0) begin
                $display("%0t: tag word with nothing expected, got char %0h hash %0h last %0b",
                         $time, tag_char, hash_value, last_of_tag);
                mismatches++;
            end
            else begin
                want = tag_words_due.pop_front();
                if (tag_char !== want.ch) begin
                    $display("%0t: tag_char expected %0h got %0h", $time, want.ch, tag_char);
                    mismatches++;
                end
                if (hash_value !== want.hash) begin
                    $display("%0t: hash_value expected %0h got %0h",
                             $time, want.hash, hash_value);
                    mismatches++;
                end
                if (last_of_tag !== want.last) begin
                    $display("%0t: last_of_tag expected %0b got %0b",
                             $time, want.last, last_of_tag);
                    mismatches++;
                end
            end
            next_hold = rx_steady ? 0 : $urandom_range(0, 9);
        end
        else if (next_hold != 0) begin
            next_hold--;
        end
        rx_hold = next_hold;
        tag_stall <= (next_hold != 0);
    end

    // Give up when neither side has moved a word for a long stretch.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((name_valid && !name_stall) || (tag_valid && !tag_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t r;
        int words_sent;
        int name_len;

        // Empty names right after reset, then one-byte names whose tags can be
        // read straight off the byte value, in both letter cases.
        add_row(8'h00, 1'b1, 1'b1, 24'h000000, "0000");
        add_row(8'h00, 1'b0, 1'b1, 24'h000000, "0000");
        add_row(8'h01, 1'b1, 1'b0, '0, '0);
        add_row(8'h00, 1'b0, 1'b1, 24'h000001, "0001");
        add_row(8'h23, 1'b1, 1'b0, '0, '0);
        add_row(8'h00, 1'b0, 1'b1, 24'h000023, "000z");
        add_row(8'h23, 1'b0, 1'b0, '0, '0);
        add_row(8'h00, 1'b1, 1'b1, 24'h000023, "000Z");
        add_row(8'h24, 1'b0, 1'b0, '0, '0);
        add_row(8'h00, 1'b1, 1'b1, 24'h000024, "0010");
        add_row(8'hFF, 1'b0, 1'b0, '0, '0);
        add_row(8'h00, 1'b0, 1'b1, 24'h0000FF, "0073");
        // A longer name pushes bits past the top of the hash and well past the range
        // of four base-36 digits, and a two-byte name follows it.
        add_row(8'hFF, 1'b0, 1'b0, '0, '0);
        add_row(8'h80, 1'b1, 1'b0, '0, '0);
        add_row(8'hAA, 1'b0, 1'b0, '0, '0);
        add_row(8'h55, 1'b1, 1'b0, '0, '0);
        add_row(8'hFE, 1'b0, 1'b0, '0, '0);
        add_row(8'h7F, 1'b1, 1'b0, '0, '0);
        add_row(8'hFF, 1'b0, 1'b0, '0, '0);
        add_row(8'hFF, 1'b1, 1'b0, '0, '0);
        add_row(8'h00, 1'b1, 1'b0, '0, '0);
        add_row(8'h5A, 1'b0, 1'b0, '0, '0);
        add_row(8'hA5, 1'b1, 1'b0, '0, '0);
        add_row(8'h00, 1'b0, 1'b0, '0, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i]);

        r.typed    = 1'b0;
        r.exp_hash = '0;
        r.exp_tag  = '0;
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            // Now and then switch either side between random pauses and running flat out.
            if ($urandom_range(0, 7) == 0)
                tx_steady = ~tx_steady;
            if ($urandom_range(0, 7) == 0)
                rx_steady = ~rx_steady;
            name_len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 24)
                                                   : $urandom_range(0, 10);
            for (int k = 0; k < name_len; k++) begin
                r.byte_v = BYTE_W'($urandom_range(1, 255));
                r.upper  = 1'($urandom_range(0, 1));
                send_word(r);
            end
            r.byte_v = NAME_END;
            r.upper  = 1'($urandom_range(0, 1));
            send_word(r);
            words_sent += name_len + 1;
        end

        name_valid <= 1'b0;
        while (tag_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && tag_words_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- name_hash_base36_tag.f -----
rtl/core/nhb_pkg.sv
rtl/core/nhb_hash.sv
rtl/core/nhb_tag.sv
rtl/core/name_hash_base36_tag.sv
tb/tb_name_hash_base36_tag.sv
